FILE: hw/rtl/cmfs_pkg.sv
// Package for the cube map face select block.
// Holds default widths, face codes and the stream width helper. No dependencies.
package cmfs_pkg;

  localparam int unsigned CompBitsDef  = 16;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FaceBits     = 3;
  localparam int unsigned FifoDepth    = 2;

  typedef enum logic [FaceBits-1:0] {
    FacePosX = 3'd0,
    FaceNegX = 3'd1,
    FacePosY = 3'd2,
    FaceNegY = 3'd3,
    FacePosZ = 3'd4,
    FaceNegZ = 3'd5
  } face_e;

  // round a bit count up to whole bytes
  function automatic int unsigned byte_round(int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

FILE: hw/rtl/cmfs_front.sv
// Front stage: picks the major axis and forms the offset face coordinates.
// Depends on cmfs_pkg.
module cmfs_front import cmfs_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = CompBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [COMPONENT_BITS-1:0] dir_x_i,
  input  logic [COMPONENT_BITS-1:0] dir_y_i,
  input  logic [COMPONENT_BITS-1:0] dir_z_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [FaceBits-1:0]       face_o,
  output logic [COMPONENT_BITS:0]   off_s_o,   // sc + ma
  output logic [COMPONENT_BITS:0]   off_t_o,   // tc + ma
  output logic [COMPONENT_BITS-1:0] ma_o
);
  localparam int unsigned N = COMPONENT_BITS;

  logic signed [N:0] x, y, z, sc, tc, mas;
  logic [N-1:0]      ax, ay, az, ma;
  face_e             face;
  logic              valid_q;
  logic [FaceBits-1:0] face_q;
  logic [N:0]        off_s_q, off_t_q;
  logic [N-1:0]      ma_q;

  assign x  = $signed({dir_x_i[N-1], dir_x_i});
  assign y  = $signed({dir_y_i[N-1], dir_y_i});
  assign z  = $signed({dir_z_i[N-1], dir_z_i});
  assign ax = x[N] ? N'(-x) : x[N-1:0];
  assign ay = y[N] ? N'(-y) : y[N-1:0];
  assign az = z[N] ? N'(-z) : z[N-1:0];

  // major axis, ties to z then y
  always_comb begin
    if (az >= ax && az >= ay) begin
      ma = az;
      if (!z[N] && z != '0) begin
        face = FacePosZ; sc = x;  tc = -y;
      end else begin
        face = FaceNegZ; sc = -x; tc = -y;
      end
    end else if (ay >= ax) begin
      ma = ay;
      if (!y[N]) begin
        face = FacePosY; sc = x; tc = z;
      end else begin
        face = FaceNegY; sc = x; tc = -z;
      end
    end else begin
      ma = ax;
      if (!x[N]) begin
        face = FacePosX; sc = -z; tc = -y;
      end else begin
        face = FaceNegX; sc = z;  tc = -y;
      end
    end
  end

  assign mas     = $signed({1'b0, ma});
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      face_q  <= face;
      off_s_q <= $unsigned(sc + mas);
      off_t_q <= $unsigned(tc + mas);
      ma_q    <= ma;
    end
  end

  assign valid_o = valid_q;
  assign face_o  = face_q;
  assign off_s_o = off_s_q;
  assign off_t_o = off_t_q;
  assign ma_o    = ma_q;
endmodule

FILE: hw/rtl/cmfs_fifo.sv
// Small register queue between the front and the divider pipeline.
// Depends on cmfs_pkg for the depth.
module cmfs_fifo import cmfs_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned PtrBits = $clog2(FifoDepth);

  logic [WIDTH-1:0]   mem_q [FifoDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;
  logic               do_push, do_pop;

  assign ready_o = cnt_q != (PtrBits+1)'(FifoDepth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule

FILE: hw/rtl/cmfs_div.sv
// Back end: restoring divider pipeline (s, t), one quotient bit per later stage.
// Depends on cmfs_pkg.
module cmfs_div import cmfs_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = CompBitsDef,
  parameter int unsigned COORD_BITS     = CoordBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [FaceBits-1:0]       face_i,
  input  logic [COMPONENT_BITS:0]   off_s_i,
  input  logic [COMPONENT_BITS:0]   off_t_i,
  input  logic [COMPONENT_BITS-1:0] ma_i,
  output logic                      valid_o,
  output logic [FaceBits-1:0]       face_o,
  output logic [COORD_BITS-1:0]     tex_s_o,
  output logic [COORD_BITS-1:0]     tex_t_o
);
  localparam int unsigned N = COMPONENT_BITS;
  localparam int unsigned C = COORD_BITS;
  localparam int unsigned Stages = C;

  logic                vld_q  [Stages];
  logic [FaceBits-1:0] face_q [Stages];
  logic [N-1:0]        ma_q   [Stages];
  logic [N:0]          rs_q   [Stages];
  logic [N:0]          rt_q   [Stages];
  logic [C:0]          qs_q   [Stages];
  logic [C:0]          qt_q   [Stages];

  // first stage: integer part of the quotient is 0, 1 or 2
  logic [N+1:0] ma1, ma2;
  logic [1:0]   qs0, qt0;
  logic [N+1:0] rs0, rt0;

  assign ma1 = (N+2)'(ma_i);
  assign ma2 = {1'b0, ma_i, 1'b0};

  always_comb begin
    if ((N+2)'(off_s_i) >= ma2) begin
      qs0 = 2'd2; rs0 = (N+2)'(off_s_i) - ma2;
    end else if ((N+2)'(off_s_i) >= ma1) begin
      qs0 = 2'd1; rs0 = (N+2)'(off_s_i) - ma1;
    end else begin
      qs0 = 2'd0; rs0 = (N+2)'(off_s_i);
    end
    if ((N+2)'(off_t_i) >= ma2) begin
      qt0 = 2'd2; rt0 = (N+2)'(off_t_i) - ma2;
    end else if ((N+2)'(off_t_i) >= ma1) begin
      qt0 = 2'd1; rt0 = (N+2)'(off_t_i) - ma1;
    end else begin
      qt0 = 2'd0; rt0 = (N+2)'(off_t_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      face_q[0] <= face_i;
      ma_q[0]   <= ma_i;
      rs_q[0]   <= rs0[N:0];
      rt_q[0]   <= rt0[N:0];
      qs_q[0]   <= {qs0, (C-1)'(0)};
      qt_q[0]   <= {qt0, (C-1)'(0)};
    end
  end

  // one fraction bit per stage
  for (genvar k = 1; k < Stages; k++) begin : g_stage
    logic [N:0] s2, t2, mw;
    logic       bs, bt;
    assign mw = (N+1)'(ma_q[k-1]);
    assign s2 = {rs_q[k-1][N-1:0], 1'b0};
    assign t2 = {rt_q[k-1][N-1:0], 1'b0};
    assign bs = s2 >= mw;
    assign bt = t2 >= mw;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        face_q[k] <= face_q[k-1];
        ma_q[k]   <= ma_q[k-1];
        rs_q[k]   <= bs ? s2 - mw : s2;
        rt_q[k]   <= bt ? t2 - mw : t2;
        qs_q[k]   <= qs_q[k-1] | ((C+1)'(bs) << (C-1-k));
        qt_q[k]   <= qt_q[k-1] | ((C+1)'(bt) << (C-1-k));
      end
    end
  end

  // saturate 1.0 and force zero for the null vector
  logic zero_ma;
  assign zero_ma = ma_q[Stages-1] == '0;
  assign valid_o = vld_q[Stages-1];
  assign face_o  = face_q[Stages-1];
  assign tex_s_o = zero_ma ? '0 : (qs_q[Stages-1][C] ? '1 : qs_q[Stages-1][C-1:0]);
  assign tex_t_o = zero_ma ? '0 : (qt_q[Stages-1][C] ? '1 : qt_q[Stages-1][C-1:0]);
endmodule

FILE: hw/rtl/cube_map_face_select.sv
// Top level of the cube map face select block.
// Depends on cmfs_pkg, cmfs_front, cmfs_fifo and cmfs_div.

// Accepts one direction vector per cycle when not stalled and returns one result
// per request. A request passes the front register, the queue, COORD_BITS
// divider stages (the first forms the integer part, each later one a quotient
// bit) and the output register. The two-entry queue between front and divider
// lets each side stall alone; once a full pipeline is released the input
// resumes in the cycle after the output does.
module cube_map_face_select import cmfs_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = CompBitsDef,
  parameter int unsigned COORD_BITS     = CoordBitsDef,
  localparam int unsigned InW  = byte_round(3 * COMPONENT_BITS),
  localparam int unsigned OutW = byte_round(FaceBits + 2 * COORD_BITS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // dir_x, dir_y, dir_z, zero pad
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // face_index, tex_s, tex_t, zero pad
);
  localparam int unsigned N  = COMPONENT_BITS;
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned QW = FaceBits + 2 * (N + 1) + N;

  logic                f_valid, f_ready, q_valid, adv, d_valid;
  logic [FaceBits-1:0] f_face, q_face, d_face;
  logic [N:0]          f_off_s, f_off_t, q_off_s, q_off_t;
  logic [N-1:0]        f_ma, q_ma;
  logic [QW-1:0]       q_data;
  logic [C-1:0]        d_s, d_t;
  logic                out_vld_q;
  logic [OutW-1:0]     out_dat_q;

  cmfs_front #(.COMPONENT_BITS(N)) u_front (
    .clk_i, .rst_ni,
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .dir_x_i (s_axis_tdata[N-1:0]),
    .dir_y_i (s_axis_tdata[2*N-1:N]),
    .dir_z_i (s_axis_tdata[3*N-1:2*N]),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .face_o  (f_face),
    .off_s_o (f_off_s),
    .off_t_o (f_off_t),
    .ma_o    (f_ma)
  );

  cmfs_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (f_valid),
    .ready_o (f_ready),
    .data_i  ({f_ma, f_off_t, f_off_s, f_face}),
    .valid_o (q_valid),
    .pop_i   (adv),
    .data_o  (q_data)
  );

  assign {q_ma, q_off_t, q_off_s, q_face} = q_data;

  // divider advances whenever the output register can take a result
  assign adv = !out_vld_q || m_axis_tready;

  cmfs_div #(.COMPONENT_BITS(N), .COORD_BITS(C)) u_div (
    .clk_i, .rst_ni,
    .en_i    (adv),
    .valid_i (q_valid),
    .face_i  (q_face),
    .off_s_i (q_off_s),
    .off_t_i (q_off_t),
    .ma_i    (q_ma),
    .valid_o (d_valid),
    .face_o  (d_face),
    .tex_s_o (d_s),
    .tex_t_o (d_t)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_dat_q <= OutW'({d_t, d_s, d_face});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_dat_q;
endmodule

FILE: hw/rtl/cmfs_checker.sv
// Port-level checker for cube_map_face_select, attached by bind.
// Depends on cmfs_pkg.
module cmfs_checker import cmfs_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = CompBitsDef,
  parameter int unsigned COORD_BITS     = CoordBitsDef,
  localparam int unsigned OutW = byte_round(FaceBits + 2 * COORD_BITS)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);
  localparam int unsigned Cap = COORD_BITS + 2 + FifoDepth;

  logic       in_acc, out_acc;
  logic [7:0] fly_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fly_q <= '0;
    end else begin
      fly_q <= fly_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[FaceBits-1:0] <= FaceBits'(FaceNegZ))
    else $error("face code out of range");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> fly_q != '0)
    else $error("result without a pending request");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fly_q <= 8'(Cap))
    else $error("more requests in flight than the pipeline holds");
endmodule

bind cube_map_face_select cmfs_checker #(
  .COMPONENT_BITS(COMPONENT_BITS),
  .COORD_BITS(COORD_BITS)
) u_cmfs_checker (
  .clk_i, .rst_ni,
  .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

FILE: test/tb_cube_map_face_select.sv
// Testbench for cube_map_face_select: directed and random direction vectors,
// checked against an in-bench predictor. Depends on cmfs_pkg and the RTL.
module tb_cube_map_face_select;
  import cmfs_pkg::*;

  localparam int unsigned InW  = byte_round(3 * 16);
  localparam int unsigned OutW = byte_round(FaceBits + 32);
  localparam int unsigned Latency = 19;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    face_e       face;
    logic [15:0] tex_s;
    logic [15:0] tex_t;
  } face_coord_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;

  face_coord_t expected_coords[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_recv;

  cube_map_face_select DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // map a face coordinate from [-ma, ma] to a saturated 16-bit fraction
  function automatic logic [15:0] coord_frac(longint c, longint ma);
    longint q;
    q = ((c + ma) * 32768) / ma;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic face_coord_t predict_face(logic signed [15:0] xi,
                                               logic signed [15:0] yi,
                                               logic signed [15:0] zi);
    longint x, y, z, ax, ay, az, sc, tc, ma;
    face_coord_t r;
    x = xi; y = yi; z = zi;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    if (az >= ax && az >= ay) begin
      ma = az;
      if (z > 0) begin r.face = FacePosZ; sc = x; tc = -y; end
      else begin r.face = FaceNegZ; sc = -x; tc = -y; end
    end else if (ay >= ax) begin
      ma = ay;
      if (y > 0) begin r.face = FacePosY; sc = x; tc = z; end
      else begin r.face = FaceNegY; sc = x; tc = -z; end
    end else begin
      ma = ax;
      if (x > 0) begin r.face = FacePosX; sc = -z; tc = -y; end
      else begin r.face = FaceNegX; sc = z; tc = -y; end
    end
    if (ma == 0) begin
      r.tex_s = '0;
      r.tex_t = '0;
    end else begin
      r.tex_s = coord_frac(sc, ma);
      r.tex_t = coord_frac(tc, ma);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // drive one direction request and wait for acceptance; valid stays high
  // until the next request or an idle phase takes it down
  task automatic send_dir(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_coords.push_back(predict_face(x, y, z));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_coords.size() != 0) @(negedge clk_i);
  endtask

  // receiver ready, with random stalls and an optional long hold-off
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    face_coord_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[34:19]};
        if (expected_coords.size() == 0) begin
          report_mismatch("unexpected result", got.face, 0);
        end else begin
          want = expected_coords.pop_front();
          if (got.face !== want.face) report_mismatch("face", got.face, want.face);
          if (got.tex_s !== want.tex_s) report_mismatch("tex_s", got.tex_s, want.tex_s);
          if (got.tex_t !== want.tex_t) report_mismatch("tex_t", got.tex_t, want.tex_t);
        end
      end
    end
  end

  task automatic test_directed();
    send_dir(16'd0, 16'd0, 16'd0);                 // all-zero vector
    send_dir(16'h7FFF, 16'd0, 16'd0);
    send_dir(16'h8000, 16'd0, 16'd0);              // most negative x
    send_dir(16'd0, 16'h7FFF, 16'd0);
    send_dir(16'd0, 16'h8000, 16'd0);
    send_dir(16'd0, 16'd0, 16'h7FFF);
    send_dir(16'd0, 16'd0, 16'h8000);
    send_dir(16'd100, 16'd100, 16'd100);           // three-way tie goes to z
    send_dir(16'hFF9C, 16'hFF9C, 16'hFF9C);
    send_dir(16'd50, 16'd50, 16'd3);               // x-y tie goes to y
    send_dir(16'd50, 16'hFFCE, 16'd3);
    send_dir(16'h8000, 16'h7FFF, 16'h8000);        // face edges, saturation
    send_dir(16'h7FFF, 16'h8001, 16'h8001);
    send_dir(16'h8000, 16'h8000, 16'h8000);
    send_dir(16'd1, 16'hFFFF, 16'd0);
    send_dir(16'hFFFF, 16'd0, 16'd1);
    send_dir(16'h7FFF, 16'h7FFF, 16'h7FFE);
    send_dir(16'h5555, 16'hAAAA, 16'h1234);
  endtask

  task automatic test_random(int unsigned n);
    logic [15:0] v[3];
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      foreach (v[j]) begin
        k = $urandom_range(9);
        if (k == 0) v[j] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        else if (k < 3) v[j] = 16'($urandom_range(8) - 4);
        else v[j] = 16'($urandom);
      end
      // occasional ties on magnitude
      if ($urandom_range(7) == 0) v[$urandom_range(2)] = -v[$urandom_range(2)];
      send_dir(v[0], v[1], v[2]);
    end
  endtask

  // hold the receiver off so the pipeline backs up into the input
  task automatic test_backpressure();
    hold_recv = 1'b1;
    fork
      begin
        for (int c = 0; c < 200; c++) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      test_random(60);
    join
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(250);
    send_idle_pct = 48;
    test_random(250);
    send_idle_pct = 0;
    recv_stall_pct = 48;
    test_random(250);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    test_random(250);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random(80);

    wait_drained();
    repeat (Latency + 10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
